// ===== rtl/ihrf_pkg.sv =====
// Shared constants and types of the Intel HEX record framer.
`timescale 1ns / 1ps
`default_nettype none
package ihrf_pkg;

	localparam int AddrW          = 16;
	localparam int ByteW          = 8;
	localparam int MaxRecordBytes = 16;
	// bytes in the open record, 0 .. MaxRecordBytes
	localparam int CntW           = $clog2(MaxRecordBytes + 1);
	localparam int IdxW           = (MaxRecordBytes > 1) ? $clog2(MaxRecordBytes) : 1;
	// byte position inside a record, 0 .. MaxRecordBytes + 4
	localparam int PosW           = $clog2(MaxRecordBytes + 5);
	// command queue depth, a power of two
	localparam int QueueDepth     = 2;
	localparam int QPtrW          = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
	localparam int QFillW         = $clog2(QueueDepth + 1);

	localparam logic [AddrW-1:0] TopAddr     = 16'hFFFF;
	localparam logic [ByteW-1:0] RecTypeData = 8'h00;
	localparam logic [ByteW-1:0] RecTypeEnd  = 8'h01;

	// one classified input beat
	typedef struct packed {
		logic [AddrW-1:0] addr;
		logic [ByteW-1:0] value;
		logic             gap;    // flush the open record before buffering
		logic             close;  // flush the record after buffering
		logic             fin;    // end record follows
	} cmd_t;

endpackage
`default_nettype wire

// ===== rtl/intel_hex_record_framer_core.sv =====
// Top level of the Intel HEX record framer: front end, command queue, back end.
//
// Usage: feed one program byte per slave beat (address and value in s_tdata,
// s_tlast on the last byte of the image). The master side streams the binary
// bytes of the records: count, address high, address low, type, data,
// checksum. m_tuser marks the count byte of every record; m_tlast marks the
// last byte caused by one input beat. A beat that closes no record yields no
// output. A gap in the address, a full record of 16 bytes or address 0xFFFF
// closes the open record; s_tlast flushes it and appends an end record (01).
// Throughput: the front end takes one beat per cycle while the two-entry
// command queue has room. The back end takes each beat from the queue in its
// idle state (it buffers the byte there unless a gap flush must go first),
// emits the record bytes in turn (count + 5 for a data record, 5 for the end
// record), and buffers the byte in a load state after a gap flush. With queue
// and back end idle, the first record byte of an accepted beat goes through
// the queue entry, the back-end state and the output register to m_tvalid.
// The output register is the only pacing point on the master side: while
// m_tready is low the back end holds, the queue fills and s_tready drops.
// Reset clears the open record, the address tracking and both valid flags.
`timescale 1ns / 1ps
`default_nettype none
module intel_hex_record_framer_core (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [23:0] s_tdata,   // [15:0] byte_addr, [23:16] byte_value
	input  wire         s_tlast,   // final_byte
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [7:0]  m_tdata,   // [7:0] out_byte
	output logic        m_tuser,   // [0] record_start
	output logic        m_tlast    // run_last
);

	ihrf_pkg::cmd_t front_cmd;
	ihrf_pkg::cmd_t back_cmd;
	logic           front_valid;
	logic           q_ready;
	logic           q_valid;
	logic           q_pop;

	// classify each beat: flush before, flush after, end of image
	ihrf_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_addr   (s_tdata[15:0]),
		.in_value  (s_tdata[23:16]),
		.in_fin    (s_tlast),
		.cmd_valid (front_valid),
		.cmd_ready (q_ready),
		.cmd       (front_cmd)
	);

	// decouple input acceptance from record emission
	ihrf_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (front_valid),
		.push_ready (q_ready),
		.push_cmd   (front_cmd),
		.pop_valid  (q_valid),
		.pop        (q_pop),
		.pop_cmd    (back_cmd)
	);

	// buffer data and walk out the records
	ihrf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (q_valid),
		.cmd_pop   (q_pop),
		.cmd       (back_cmd),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_byte  (m_tdata),
		.out_start (m_tuser),
		.out_last  (m_tlast)
	);

	// a full queue always offers a command to the back end
	a_full_has_data: assert property (@(posedge clk) disable iff (!arst_n)
		!q_ready |-> q_valid)
		else $error("command queue full but empty");

	// the count byte never ends a run: header bytes always follow it
	a_start_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> !m_tlast)
		else $error("record count byte flagged as last");

	// record count never exceeds the record capacity
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser) |-> (m_tdata <= 8'(ihrf_pkg::MaxRecordBytes)))
		else $error("record count out of range");

endmodule
`default_nettype wire

// ===== rtl/ihrf_front.sv =====
// Front end: accepts input beats and classifies them into back-end commands.
`timescale 1ns / 1ps
`default_nettype none
module ihrf_front (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           in_valid,
	output logic                          in_ready,
	input  wire  [ihrf_pkg::AddrW-1:0]    in_addr,
	input  wire  [ihrf_pkg::ByteW-1:0]    in_value,
	input  wire                           in_fin,
	output logic                          cmd_valid,
	input  wire                           cmd_ready,
	output ihrf_pkg::cmd_t                cmd
);

	logic [ihrf_pkg::AddrW-1:0] prev_addr_q;
	logic [ihrf_pkg::CntW-1:0]  count_q;
	logic [ihrf_pkg::CntW-1:0]  base_cnt;
	logic [ihrf_pkg::CntW-1:0]  new_cnt;
	logic [ihrf_pkg::AddrW:0]   next_addr;
	logic                       gap;
	logic                       close;
	logic                       accept;

	assign in_ready  = cmd_ready;
	assign cmd_valid = in_valid;
	assign accept    = in_valid && cmd_ready;

	// wide compare: previous address plus one never wraps
	assign next_addr = {1'b0, prev_addr_q} + (ihrf_pkg::AddrW + 1)'(1);
	assign gap       = (count_q != '0) && ({1'b0, in_addr} != next_addr);
	assign base_cnt  = gap ? '0 : count_q;
	assign new_cnt   = base_cnt + ihrf_pkg::CntW'(1);
	assign close     = (new_cnt >= ihrf_pkg::CntW'(ihrf_pkg::MaxRecordBytes))
		|| (in_addr == ihrf_pkg::TopAddr) || in_fin;

	always_comb begin
		cmd.addr  = in_addr;
		cmd.value = in_value;
		cmd.gap   = gap;
		cmd.close = close;
		cmd.fin   = in_fin;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_addr_q <= '0;
			count_q     <= '0;
		end else if (accept) begin
			prev_addr_q <= in_addr;
			count_q     <= close ? '0 : new_cnt;
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ihrf_queue.sv =====
// Short command queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module ihrf_queue (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push_valid,
	output logic            push_ready,
	input  ihrf_pkg::cmd_t  push_cmd,
	output logic            pop_valid,
	input  wire             pop,
	output ihrf_pkg::cmd_t  pop_cmd
);

	ihrf_pkg::cmd_t              mem_q [ihrf_pkg::QueueDepth];
	logic [ihrf_pkg::QPtrW-1:0]  wr_ptr_q;
	logic [ihrf_pkg::QPtrW-1:0]  rd_ptr_q;
	logic [ihrf_pkg::QFillW-1:0] fill_q;
	logic                        do_push;
	logic                        do_pop;

	assign push_ready = (fill_q != ihrf_pkg::QFillW'(ihrf_pkg::QueueDepth));
	assign pop_valid  = (fill_q != '0);
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && pop_valid;
	assign pop_cmd    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + ihrf_pkg::QPtrW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + ihrf_pkg::QPtrW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + ihrf_pkg::QFillW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - ihrf_pkg::QFillW'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== rtl/ihrf_back.sv =====
// Back end: buffers record data and emits data and end records byte by byte.
`timescale 1ns / 1ps
`default_nettype none
module ihrf_back (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cmd_valid,
	output logic                        cmd_pop,
	input  ihrf_pkg::cmd_t              cmd,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [ihrf_pkg::ByteW-1:0]  out_byte,
	output logic                        out_start,
	output logic                        out_last
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_GAP  = 5'b00010,
		ST_LOAD = 5'b00100,
		ST_REC  = 5'b01000,
		ST_END  = 5'b10000
	} state_t;

	state_t                      state_q;
	ihrf_pkg::cmd_t              cmd_q;
	logic [ihrf_pkg::ByteW-1:0]  buf_q [ihrf_pkg::MaxRecordBytes];
	logic [ihrf_pkg::CntW-1:0]   count_q;
	logic [ihrf_pkg::AddrW-1:0]  start_addr_q;
	logic [ihrf_pkg::ByteW-1:0]  sum_q;
	logic [ihrf_pkg::AddrW-1:0]  end_addr_q;
	logic [ihrf_pkg::PosW-1:0]   pos_q;

	logic                        out_valid_q;
	logic [ihrf_pkg::ByteW-1:0]  out_byte_q;
	logic                        out_start_q;
	logic                        out_last_q;

	logic                        emitting;
	logic                        emit;
	logic                        load_en;
	ihrf_pkg::cmd_t              load_cmd;
	logic [ihrf_pkg::PosW-1:0]   rec_last_pos;
	logic [ihrf_pkg::PosW-1:0]   data_pos;
	logic                        byte_last;
	logic [ihrf_pkg::ByteW-1:0]  cnt8;
	logic [ihrf_pkg::ByteW-1:0]  rec_sum;
	logic [ihrf_pkg::ByteW-1:0]  end_sum;
	logic [ihrf_pkg::ByteW-1:0]  rec_byte;
	logic [ihrf_pkg::ByteW-1:0]  end_byte;
	logic [ihrf_pkg::ByteW-1:0]  emit_byte;
	logic                        emit_last;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign out_start = out_start_q;
	assign out_last  = out_last_q;

	assign emitting = (state_q == ST_GAP) || (state_q == ST_REC) || (state_q == ST_END);
	assign emit     = emitting && (!out_valid_q || out_ready);
	assign cmd_pop  = (state_q == ST_IDLE) && cmd_valid;

	// buffer the byte straight from the queue unless a flush must go first
	assign load_en  = (cmd_pop && !cmd.gap) || (state_q == ST_LOAD);
	assign load_cmd = (state_q == ST_LOAD) ? cmd_q : cmd;

	assign cnt8         = ihrf_pkg::ByteW'(count_q);
	assign rec_last_pos = ihrf_pkg::PosW'(count_q) + ihrf_pkg::PosW'(4);
	assign data_pos     = pos_q - ihrf_pkg::PosW'(4);
	assign rec_sum      = sum_q + cnt8 + start_addr_q[15:8] + start_addr_q[7:0];
	assign end_sum      = end_addr_q[15:8] + end_addr_q[7:0] + ihrf_pkg::ByteW'(1);
	assign byte_last    = (state_q == ST_END) ? (pos_q == ihrf_pkg::PosW'(4))
		: (pos_q == rec_last_pos);

	always_comb begin
		priority if (pos_q == ihrf_pkg::PosW'(0)) begin
			rec_byte = cnt8;
		end else if (pos_q == ihrf_pkg::PosW'(1)) begin
			rec_byte = start_addr_q[15:8];
		end else if (pos_q == ihrf_pkg::PosW'(2)) begin
			rec_byte = start_addr_q[7:0];
		end else if (pos_q == ihrf_pkg::PosW'(3)) begin
			rec_byte = ihrf_pkg::RecTypeData;
		end else if (pos_q < rec_last_pos) begin
			rec_byte = buf_q[data_pos[ihrf_pkg::IdxW-1:0]];
		end else begin
			rec_byte = ~rec_sum + ihrf_pkg::ByteW'(1);
		end
	end

	always_comb begin
		priority if (pos_q == ihrf_pkg::PosW'(0)) begin
			end_byte = '0;
		end else if (pos_q == ihrf_pkg::PosW'(1)) begin
			end_byte = end_addr_q[15:8];
		end else if (pos_q == ihrf_pkg::PosW'(2)) begin
			end_byte = end_addr_q[7:0];
		end else if (pos_q == ihrf_pkg::PosW'(3)) begin
			end_byte = ihrf_pkg::RecTypeEnd;
		end else begin
			end_byte = ~end_sum + ihrf_pkg::ByteW'(1);
		end
	end

	always_comb begin
		unique case (state_q)
			ST_GAP: begin
				emit_byte = rec_byte;
				emit_last = byte_last && !cmd_q.close;
			end
			ST_REC: begin
				emit_byte = rec_byte;
				emit_last = byte_last && !cmd_q.fin;
			end
			ST_END: begin
				emit_byte = end_byte;
				emit_last = byte_last;
			end
			default: begin
				emit_byte = '0;
				emit_last = 1'b0;
			end
		endcase
	end

	// payload: record buffer, latched command, output byte
	always_ff @(posedge clk) begin
		if (load_en) begin
			buf_q[count_q[ihrf_pkg::IdxW-1:0]] <= load_cmd.value;
		end
		if (cmd_pop) begin
			cmd_q <= cmd;
		end
		if (emit) begin
			out_byte_q  <= emit_byte;
			out_start_q <= (pos_q == '0);
			out_last_q  <= emit_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			count_q      <= '0;
			start_addr_q <= '0;
			sum_q        <= '0;
			end_addr_q   <= '0;
			pos_q        <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (load_en) begin
				count_q <= count_q + ihrf_pkg::CntW'(1);
				if (count_q == '0) begin
					start_addr_q <= load_cmd.addr;
					sum_q        <= load_cmd.value;
				end else begin
					sum_q <= sum_q + load_cmd.value;
				end
			end

			if (emit) begin
				pos_q <= byte_last ? '0 : pos_q + ihrf_pkg::PosW'(1);
				if (byte_last && (state_q != ST_END)) begin
					end_addr_q <= start_addr_q + ihrf_pkg::AddrW'(count_q);
					count_q    <= '0;
					sum_q      <= '0;
				end
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd_pop) begin
						if (cmd.gap) begin
							state_q <= ST_GAP;
						end else if (cmd.close) begin
							state_q <= ST_REC;
						end
					end
				end
				ST_GAP: begin
					if (emit && byte_last) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= cmd_q.close ? ST_REC : ST_IDLE;
				end
				ST_REC: begin
					if (emit && byte_last) begin
						state_q <= cmd_q.fin ? ST_END : ST_IDLE;
					end
				end
				ST_END: begin
					if (emit && byte_last) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
// Self-checking bench for the Intel HEX record framer: directed rows, then random address runs and single bytes.
`timescale 1ns / 1ps
module tb;

	localparam int IdleLimit   = 2000;
	localparam int RandomItems = 320;
	localparam int DrainCycles = 20;

	typedef struct {
		logic [ihrf_pkg::AddrW-1:0] addr;
		logic [ihrf_pkg::ByteW-1:0] value;
		logic                       fin;
		int                         n_typed;  // 0: take the bytes from the framing model
	} stim_row_t;

	typedef struct packed {
		logic [ihrf_pkg::ByteW-1:0] data;
		logic                       rec_start;
		logic                       run_end;
	} frame_byte_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [23:0] s_tdata  = '0;
	logic        s_tlast  = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tuser;
	logic        m_tlast;

	intel_hex_record_framer_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// framing model state
	logic [ihrf_pkg::ByteW-1:0] rec_buf [ihrf_pkg::MaxRecordBytes];
	int unsigned                buf_cnt   = 0;
	logic [ihrf_pkg::AddrW-1:0] rec_base  = '0;
	logic [ihrf_pkg::AddrW-1:0] last_addr = '0;
	logic [ihrf_pkg::AddrW-1:0] end_addr  = '0;
	logic [ihrf_pkg::ByteW-1:0] data_sum  = '0;

	frame_byte_t beat_bytes[$];   // bytes caused by the beat just framed
	frame_byte_t bytes_due[$];    // bytes still owed by the framer, oldest first
	frame_byte_t typed_bytes[$];  // hand-written bytes for the typed rows
	stim_row_t   stim_rows[$];
	frame_byte_t due_head;

	int errors      = 0;
	int idle_cycles = 0;
	int stall_left  = 0;
	int items_sent  = 0;
	bit no_idle     = 1'b0;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		errors++;
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 65)
			return 0;
		else if (r < 92)
			return $urandom_range(1, 3);
		else
			return $urandom_range(8, 30);
	endfunction

	function automatic void push_byte(input logic [ihrf_pkg::ByteW-1:0] b, input logic st);
		frame_byte_t fb;
		fb.data      = b;
		fb.rec_start = st;
		fb.run_end   = 1'b0;
		beat_bytes.push_back(fb);
	endfunction

	function automatic void close_data_record();
		logic [ihrf_pkg::ByteW-1:0] cnt;
		logic [ihrf_pkg::ByteW-1:0] sum;
		cnt = 8'(buf_cnt);
		sum = data_sum + cnt + rec_base[15:8] + rec_base[7:0];
		push_byte(cnt, 1'b1);
		push_byte(rec_base[15:8], 1'b0);
		push_byte(rec_base[7:0], 1'b0);
		push_byte(ihrf_pkg::RecTypeData, 1'b0);
		for (int k = 0; k < buf_cnt; k++)
			push_byte(rec_buf[k], 1'b0);
		push_byte(8'h00 - sum, 1'b0);
		end_addr = rec_base + 16'(buf_cnt);
		buf_cnt  = 0;
		data_sum = '0;
	endfunction

	function automatic void close_end_record();
		logic [ihrf_pkg::ByteW-1:0] sum;
		sum = end_addr[15:8] + end_addr[7:0] + ihrf_pkg::RecTypeEnd;
		push_byte(8'h00, 1'b1);
		push_byte(end_addr[15:8], 1'b0);
		push_byte(end_addr[7:0], 1'b0);
		push_byte(ihrf_pkg::RecTypeEnd, 1'b0);
		push_byte(8'h00 - sum, 1'b0);
	endfunction

	// advance the framing model by one program byte, leave its bytes in beat_bytes
	function automatic void frame_input_byte(input logic [ihrf_pkg::AddrW-1:0] a,
			input logic [ihrf_pkg::ByteW-1:0] v, input logic fin);
		beat_bytes.delete();
		// compare in 17 bits: after 0xFFFF no address continues the run
		if (buf_cnt > 0 && {1'b0, a} != {1'b0, last_addr} + 17'd1)
			close_data_record();
		if (buf_cnt == 0) begin
			rec_base = a;
			data_sum = '0;
		end
		rec_buf[buf_cnt] = v;
		buf_cnt++;
		data_sum  = data_sum + v;
		last_addr = a;
		if (buf_cnt >= ihrf_pkg::MaxRecordBytes || a == ihrf_pkg::TopAddr || fin)
			close_data_record();
		if (fin)
			close_end_record();
		if (beat_bytes.size() > 0)
			beat_bytes[beat_bytes.size() - 1].run_end = 1'b1;
	endfunction

	function automatic void add_row(input logic [ihrf_pkg::AddrW-1:0] a,
			input logic [ihrf_pkg::ByteW-1:0] v, input logic fin, input int n_typed = 0);
		stim_row_t r;
		r.addr    = a;
		r.value   = v;
		r.fin     = fin;
		r.n_typed = n_typed;
		stim_rows.push_back(r);
	endfunction

	function automatic void want(input logic [ihrf_pkg::ByteW-1:0] b, input logic st);
		frame_byte_t fb;
		fb.data      = b;
		fb.rec_start = st;
		fb.run_end   = 1'b0;
		typed_bytes.push_back(fb);
	endfunction

	task automatic send_byte(input logic [ihrf_pkg::AddrW-1:0] a,
			input logic [ihrf_pkg::ByteW-1:0] v, input logic fin, input int n_typed);
		int          gap;
		frame_byte_t fb;
		s_tvalid <= 1'b1;
		s_tdata  <= {v, a};
		s_tlast  <= fin;
		do @(posedge clk); while (!s_tready);
		frame_input_byte(a, v, fin);
		if (n_typed > 0) begin
			for (int k = 0; k < n_typed; k++) begin
				fb         = typed_bytes.pop_front();
				fb.run_end = (k == n_typed - 1);
				bytes_due.push_back(fb);
			end
		end else begin
			foreach (beat_bytes[k])
				bytes_due.push_back(beat_bytes[k]);
		end
		items_sent++;
		gap = no_idle ? 0 : pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// consecutive addresses; a broken run skips or repeats one address halfway
	task automatic send_run(input logic [ihrf_pkg::AddrW-1:0] start, input int len,
			input logic fin_last, input bit broken);
		logic [ihrf_pkg::AddrW-1:0] a;
		a = start;
		for (int k = 0; k < len; k++) begin
			if (broken && k == len / 2 && k > 0)
				a = $urandom_range(0, 1) ? a + 16'd1 : a - 16'd1;
			send_byte(a, 8'($urandom_range(0, 255)), fin_last && k == len - 1, 0);
			a = a + 16'd1;
		end
	endtask

	function automatic logic [ihrf_pkg::AddrW-1:0] pick_start();
		case ($urandom_range(0, 3))
			0: return 16'hFFFF - 16'($urandom_range(0, 20));
			1: return 16'($urandom_range(0, 20));
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// receive side: check each beat, then stall at random
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (bytes_due.size() == 0) begin
				report_mismatch($sformatf("unexpected beat data=%02h", m_tdata));
			end else begin
				due_head = bytes_due.pop_front();
				if (m_tdata !== due_head.data)
					report_mismatch($sformatf("out_byte %02h, want %02h", m_tdata,
						due_head.data));
				if (m_tuser !== due_head.rec_start)
					report_mismatch($sformatf("record_start %b, want %b (byte %02h)",
						m_tuser, due_head.rec_start, due_head.data));
				if (m_tlast !== due_head.run_end)
					report_mismatch($sformatf("run_last %b, want %b (byte %02h)",
						m_tlast, due_head.run_end, due_head.data));
			end
		end
		if (stall_left > 0) begin
			m_tready   <= 1'b0;
			stall_left <= stall_left - 1;
		end else if (!no_idle && $urandom_range(0, 3) == 0) begin
			stall_left <= pick_gap();
			m_tready   <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// watchdog: stop when nothing moves on either side for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles <= 0;
		else if (arst_n)
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IdleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	initial begin
		int dir_count;
		bit paused;
		paused = 1'b0;

		// top of memory and final together; end address wraps to 0000
		add_row(ihrf_pkg::TopAddr, 8'hFF, 1'b1, 11);
		want(8'h01, 1'b1); want(8'hFF, 1'b0); want(8'hFF, 1'b0);
		want(ihrf_pkg::RecTypeData, 1'b0);
		want(8'hFF, 1'b0); want(8'h02, 1'b0);
		want(8'h00, 1'b1); want(8'h00, 1'b0); want(8'h00, 1'b0);
		want(ihrf_pkg::RecTypeEnd, 1'b0);
		want(8'hFF, 1'b0);
		// lowest address and value, single-byte image
		add_row(16'h0000, 8'h00, 1'b1, 11);
		want(8'h01, 1'b1); want(8'h00, 1'b0); want(8'h00, 1'b0);
		want(ihrf_pkg::RecTypeData, 1'b0);
		want(8'h00, 1'b0); want(8'hFF, 1'b0);
		want(8'h00, 1'b1); want(8'h00, 1'b0); want(8'h01, 1'b0);
		want(ihrf_pkg::RecTypeEnd, 1'b0);
		want(8'hFE, 1'b0);
		// full record closes on its sixteenth byte
		for (int k = 0; k < ihrf_pkg::MaxRecordBytes; k++)
			add_row(16'h1000 + 16'(k), 8'(k * 17), 1'b0);
		add_row(16'h1010, 8'h5A, 1'b0);   // opens a record, no output
		add_row(16'h2000, 8'hC3, 1'b0);   // address gap
		add_row(16'hFFFE, 8'h81, 1'b0);   // address gap
		add_row(ihrf_pkg::TopAddr, 8'h7E, 1'b0);  // top of memory closes the record
		add_row(16'h0000, 8'h01, 1'b0);   // no wrap into the closed record
		add_row(16'h0001, 8'h80, 1'b1);   // flush and end record
		add_row(16'h3000, 8'h11, 1'b0);
		add_row(16'h4000, 8'h22, 1'b1);   // gap and final on the same beat

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i])
			send_byte(stim_rows[i].addr, stim_rows[i].value, stim_rows[i].fin,
				stim_rows[i].n_typed);
		dir_count = items_sent;

		while (items_sent < dir_count + RandomItems) begin
			if (!paused && items_sent >= dir_count + 150) begin
				// hold the sender until every owed byte is out
				s_tvalid <= 1'b0;
				while (bytes_due.size() != 0) @(posedge clk);
				paused = 1'b1;
			end
			no_idle = (items_sent >= dir_count + 220 && items_sent < dir_count + 280);
			case ($urandom_range(0, 9))
				7, 8: begin
					repeat ($urandom_range(1, 4))
						send_byte(16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)),
							$urandom_range(0, 7) == 0, 0);
				end
				9: send_run(pick_start(), $urandom_range(2, 24), $urandom_range(0, 3) == 0, 1'b1);
				default: begin
					send_run(pick_start(),
						($urandom_range(0, 7) == 0) ? $urandom_range(17, 48)
							: $urandom_range(1, 16),
						$urandom_range(0, 3) == 0, 1'b0);
				end
			endcase
		end
		no_idle = 1'b0;

		s_tvalid <= 1'b0;
		while (bytes_due.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
